// ===== src/shake_and_tilt_detector_assert.svh =====
// Assertion macros for the shake and tilt detector RTL.
`ifndef SHAKE_AND_TILT_DETECTOR_ASSERT_SVH
`define SHAKE_AND_TILT_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SAT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define SAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/sat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// Shared widths, constants and tables of the shake and tilt detector.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CNT_W            = 5;   // indexes the 22-entry arctangent table
  localparam int VEC_W            = 28;  // CORDIC vector width
  localparam int ANG_W            = 25;  // angle, 1/256 hundredth degree
  localparam int SQRT_STEPS       = 24;
  localparam int BASE_ANG         = 4608000;

  localparam logic [1:0] SENS_300 = 2'd0;
  localparam logic [1:0] SENS_800 = 2'd2;

  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;
  localparam logic [2:0] DIR_FUP   = 3'd5;
  localparam logic [2:0] DIR_FDOWN = 3'd6;

  localparam logic [1:0] LVL_GENTLE     = 2'd0;
  localparam logic [1:0] LVL_VIGOROUS   = 2'd1;
  localparam logic [1:0] LVL_AGGRESSIVE = 2'd2;

  localparam logic [2:0] REG_SHAKE_EN  = 3'd0;
  localparam logic [2:0] REG_SHAKE_SEN = 3'd1;
  localparam logic [2:0] REG_SHAKE_DB  = 3'd2;
  localparam logic [2:0] REG_TILT_EN   = 3'd3;
  localparam logic [2:0] REG_TILT_THR  = 3'd4;

  // Squared magnitude bounds (1000+T)^2 and (1000-T)^2; zero means no low bound.
  localparam logic [23:0] HI_AGGR = 24'd6250000;

  function automatic logic [23:0] hi_base(input logic [1:0] sens);
    case (sens)
      SENS_300: hi_base = 24'd1690000;
      SENS_800: hi_base = 24'd3240000;
      default:  hi_base = 24'd2250000;
    endcase
  endfunction

  function automatic logic [23:0] lo_base(input logic [1:0] sens);
    case (sens)
      SENS_300: lo_base = 24'd490000;
      SENS_800: lo_base = 24'd40000;
      default:  lo_base = 24'd250000;
    endcase
  endfunction

  function automatic logic [23:0] hi_vig(input logic [1:0] sens);
    case (sens)
      SENS_300: hi_vig = 24'd2102500;
      SENS_800: hi_vig = 24'd4840000;
      default:  hi_vig = 24'd3062500;
    endcase
  endfunction

  function automatic logic [23:0] lo_vig(input logic [1:0] sens);
    case (sens)
      SENS_300: lo_vig = 24'd302500;
      SENS_800: lo_vig = 24'd0;
      default:  lo_vig = 24'd62500;
    endcase
  endfunction

  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [CNT_W-1:0] i);
    case (i)
      5'd0:  atan_tab = 25'sd1152000;
      5'd1:  atan_tab = 25'sd680065;
      5'd2:  atan_tab = 25'sd359328;
      5'd3:  atan_tab = 25'sd182400;
      5'd4:  atan_tab = 25'sd91554;
      5'd5:  atan_tab = 25'sd45822;
      5'd6:  atan_tab = 25'sd22916;
      5'd7:  atan_tab = 25'sd11459;
      5'd8:  atan_tab = 25'sd5730;
      5'd9:  atan_tab = 25'sd2865;
      5'd10: atan_tab = 25'sd1432;
      5'd11: atan_tab = 25'sd716;
      5'd12: atan_tab = 25'sd358;
      5'd13: atan_tab = 25'sd179;
      5'd14: atan_tab = 25'sd90;
      5'd15: atan_tab = 25'sd45;
      5'd16: atan_tab = 25'sd22;
      5'd17: atan_tab = 25'sd11;
      5'd18: atan_tab = 25'sd6;
      5'd19: atan_tab = 25'sd3;
      5'd20: atan_tab = 25'sd1;
      5'd21: atan_tab = 25'sd1;
      default: atan_tab = 25'sd0;
    endcase
  endfunction

  // Magnitude rounded half away from zero to hundredths, saturated at 18000.
  function automatic logic [14:0] cdeg_mag(input logic signed [ANG_W-1:0] v);
    logic [ANG_W-1:0] m;
    logic [ANG_W-1:0] r;
    m = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
    r = (m + ANG_W'(128)) >> 8;
    cdeg_mag = (r > ANG_W'(18000)) ? 15'd18000 : r[14:0];
  endfunction

endpackage

// ===== src/shake_and_tilt_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shake_and_tilt_detector
// Shake and tilt orientation detector for one 3-axis accelerometer sample.
// ----------------------------------------------------------------------------
// One sample request is worked on at a time. A sample that reaches the
// angle path is held longest, by the bit-serial square root and by the
// shared CORDIC unit (16 steps by default), which runs pitch and then
// roll. A sample that the face tests classify skips both, and one with
// tilt disabled also skips the tilt classification. The result sits in
// an output register, so the next sample can be taken while it waits.
// Configuration lives on an APB-style port at byte addresses 4*i.
module shake_and_tilt_detector import sat_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // accel_x[11:0], accel_y[23:12], accel_z[35:24], now_ms[67:36], zeros above
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // shake_event[0], shake_level[2:1], tilt_event[3], tilt_direction[6:4],
  // tilt_angle[21:7], zeros above
  output logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "shake_and_tilt_detector_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SHK  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_CP   = 3'd4;
  localparam logic [2:0] ST_CR   = 3'd5;
  localparam logic [2:0] ST_TCLS = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  // Configuration registers.
  logic        shake_en_r, tilt_en_r;
  logic [1:0]  shake_sen_r;
  logic [15:0] shake_db_r;
  logic [14:0] tilt_thr_r;

  // Detector state.
  logic [31:0] last_time_r;
  logic [1:0]  last_lvl_r;
  logic [2:0]  last_dir_r;
  logic [14:0] last_ang_r;

  // Per-sample working registers.
  logic [2:0]         state_r, state_nxt;
  logic signed [11:0] x_r, y_r, z_r;
  logic [31:0]        now_r;
  logic [1:0]         cnt_r;
  logic [23:0]        s_r, syz_r;
  logic               shake_ev_r, tilt_ev_r;
  logic [14:0]        ap_r;
  logic               p_pos_r;
  logic [2:0]         cand_dir_r;
  logic [14:0]        cand_ang_r;
  logic               out_valid_r;
  logic [23:0]        out_data_r;

  logic cfg_wr, accept, face_dn, face_up, out_load;
  logic signed [11:0] sq_op;
  logic [23:0] sq;
  logic exceed, ex_aggr, ex_vig;
  logic sqrt_start, sqrt_done;
  logic [23:0] root;
  logic cor_start, cor_done;
  logic signed [VEC_W-1:0] cor_y, cor_x, x_ext;
  logic signed [ANG_W-1:0] cor_ang;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    case (cfg_paddr[4:2])
      REG_SHAKE_EN:  cfg_prdata = {31'd0, shake_en_r};
      REG_SHAKE_SEN: cfg_prdata = {30'd0, shake_sen_r};
      REG_SHAKE_DB:  cfg_prdata = {16'd0, shake_db_r};
      REG_TILT_EN:   cfg_prdata = {31'd0, tilt_en_r};
      REG_TILT_THR:  cfg_prdata = {17'd0, tilt_thr_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Squares are formed one axis per cycle on a single 12x12 multiplier.
  always_comb begin
    case (cnt_r)
      2'd0:    sq_op = x_r;
      2'd1:    sq_op = y_r;
      default: sq_op = z_r;
    endcase
  end
  assign sq = 24'(sq_op * sq_op);

  // The deviation test compares the squared magnitude with squared bounds,
  // which avoids a square root on the shake path.
  assign exceed  = (s_r > hi_base(shake_sen_r)) || (s_r < lo_base(shake_sen_r));
  assign ex_vig  = (s_r > hi_vig(shake_sen_r)) || (s_r < lo_vig(shake_sen_r));
  assign ex_aggr = (s_r > HI_AGGR);

  assign face_dn = (z_r < -12'sd700);
  assign face_up = (z_r > 12'sd700) && (x_r > -12'sd300) && (x_r < 12'sd300) &&
                   (y_r > -12'sd300) && (y_r < 12'sd300);

  assign sqrt_start = (state_r == ST_SHK) && tilt_en_r && !face_dn && !face_up;
  assign cor_start  = ((state_r == ST_SQRT) && sqrt_done) ||
                      ((state_r == ST_CP) && cor_done);

  // Pitch uses (-x, sqrt(y^2+z^2)) and roll uses (y, z), all scaled by 4096.
  assign x_ext = VEC_W'(x_r);
  always_comb begin
    if (state_r == ST_SQRT) begin
      cor_y = (-x_ext) <<< 12;
      cor_x = VEC_W'({1'b0, root});
    end else begin
      cor_y = VEC_W'(y_r) <<< 12;
      cor_x = VEC_W'(z_r) <<< 12;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SQ;
      ST_SQ:   if (cnt_r == 2'd2) state_nxt = ST_SHK;
      ST_SHK: begin
        if (!tilt_en_r) state_nxt = ST_OUT;
        else if (face_dn || face_up) state_nxt = ST_TCLS;
        else state_nxt = ST_SQRT;
      end
      ST_SQRT: if (sqrt_done) state_nxt = ST_CP;
      ST_CP:   if (cor_done) state_nxt = ST_CR;
      ST_CR:   if (cor_done) state_nxt = ST_TCLS;
      ST_TCLS: state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      shake_en_r  <= 1'b0;
      shake_sen_r <= 2'd1;
      shake_db_r  <= 16'd500;
      tilt_en_r   <= 1'b0;
      tilt_thr_r  <= 15'd3000;
      last_time_r <= '0;
      last_lvl_r  <= LVL_GENTLE;
      last_dir_r  <= DIR_NONE;
      last_ang_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_SHAKE_EN: begin
            shake_en_r <= cfg_pwdata[0];
            if (!cfg_pwdata[0]) last_lvl_r <= LVL_GENTLE;
          end
          REG_SHAKE_SEN: shake_sen_r <= cfg_pwdata[1:0];
          REG_SHAKE_DB:  shake_db_r  <= cfg_pwdata[15:0];
          REG_TILT_EN: begin
            tilt_en_r <= cfg_pwdata[0];
            if (!cfg_pwdata[0]) begin
              last_dir_r <= DIR_NONE;
              last_ang_r <= '0;
            end
          end
          REG_TILT_THR:  tilt_thr_r  <= cfg_pwdata[14:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            x_r        <= in_tdata[11:0];
            y_r        <= in_tdata[23:12];
            z_r        <= in_tdata[35:24];
            now_r      <= in_tdata[67:36];
            cnt_r      <= 2'd0;
            s_r        <= '0;
            syz_r      <= '0;
            shake_ev_r <= 1'b0;
            tilt_ev_r  <= 1'b0;
          end
        end
        ST_SQ: begin
          s_r   <= s_r + sq;
          if (cnt_r != 2'd0) syz_r <= syz_r + sq;
          cnt_r <= cnt_r + 1'b1;
        end
        ST_SHK: begin
          if (shake_en_r && exceed && ((now_r - last_time_r) > {16'd0, shake_db_r})) begin
            last_time_r <= now_r;
            shake_ev_r  <= 1'b1;
            if (ex_aggr) last_lvl_r <= LVL_AGGRESSIVE;
            else if (ex_vig) last_lvl_r <= LVL_VIGOROUS;
            else last_lvl_r <= LVL_GENTLE;
          end
          ap_r    <= '0;
          p_pos_r <= 1'b0;
          if (face_dn) begin
            cand_dir_r <= DIR_FDOWN;
            cand_ang_r <= 15'd18000;
          end else begin
            cand_dir_r <= DIR_FUP;
            cand_ang_r <= '0;
          end
        end
        ST_CP: begin
          if (cor_done) begin
            ap_r    <= cdeg_mag(cor_ang);
            p_pos_r <= !cor_ang[ANG_W-1] && (cdeg_mag(cor_ang) != '0);
          end
        end
        ST_CR: begin
          if (cor_done) begin
            // Pitch wins only when strictly larger; ties go to roll.
            if (cdeg_mag(cor_ang) > tilt_thr_r || ap_r > tilt_thr_r) begin
              if (ap_r > cdeg_mag(cor_ang)) begin
                cand_dir_r <= p_pos_r ? DIR_UP : DIR_DOWN;
                cand_ang_r <= ap_r;
              end else begin
                cand_dir_r <= (!cor_ang[ANG_W-1] && (cdeg_mag(cor_ang) != '0)) ?
                              DIR_RIGHT : DIR_LEFT;
                cand_ang_r <= cdeg_mag(cor_ang);
              end
            end else begin
              cand_dir_r <= DIR_NONE;
              cand_ang_r <= '0;
            end
          end
        end
        ST_TCLS: begin
          if (cand_dir_r != last_dir_r) begin
            last_dir_r <= cand_dir_r;
            last_ang_r <= cand_ang_r;
            tilt_ev_r  <= (cand_dir_r != DIR_NONE);
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {2'b00, last_ang_r, last_dir_r, tilt_ev_r, last_lvl_r, shake_ev_r};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  sat_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .v     (syz_r),
    .done  (sqrt_done),
    .root  (root)
  );

  sat_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (cor_ang)
  );

  `SAT_ASSERT_NEXT(a_accept_starts, accept, state_r == ST_SQ)
  `SAT_ASSERT_IMPL(a_sqrt_done_in_sqrt, sqrt_done, state_r == ST_SQRT)
  `SAT_ASSERT_IMPL(a_cordic_done_in_angle, cor_done, state_r == ST_CP || state_r == ST_CR)
  `SAT_ASSERT_IMPL(a_tilt_event_has_dir, out_valid_r && out_data_r[3], out_data_r[6:4] != DIR_NONE)

endmodule

// ===== src/sat_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_isqrt
// Bit-serial square root of v * 2^24, one result bit per cycle.
// ----------------------------------------------------------------------------
module sat_isqrt import sat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] v,
  output logic        done,
  output logic [23:0] root
);

  logic [47:0] rad_r;
  logic [25:0] rem_r;
  logic [23:0] root_r;
  logic [CNT_W-1:0] cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [27:0] rem_sh;
  logic [27:0] trial;

  assign rem_sh = {rem_r, rad_r[47:46]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= {v, 24'd0};
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[45:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= 26'(rem_sh - trial);
          root_r <= {root_r[22:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[25:0];
          root_r <= {root_r[22:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== src/sat_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_cordic
// Vectoring CORDIC for atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module sat_cordic import sat_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VEC_W-1:0] y_in,
  input  logic signed [VEC_W-1:0] x_in,
  output logic                    done,
  output logic signed [ANG_W-1:0] angle
);

  logic signed [VEC_W-1:0] x_r, y_r, dx, dy;
  logic signed [ANG_W-1:0] a_r;
  logic [CNT_W-1:0]        i_r;
  logic busy_r, done_r, zero_r;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        zero_r <= (x_in == '0) && (y_in == '0);
        if (x_in < 0) begin
          x_r <= -x_in;
          y_r <= -y_in;
          a_r <= (y_in >= 0) ? ANG_W'(BASE_ANG) : -ANG_W'(BASE_ANG);
        end else begin
          x_r <= x_in;
          y_r <= y_in;
          a_r <= '0;
        end
      end else if (busy_r) begin
        if (!zero_r) begin
          if (y_r >= 0) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            a_r <= a_r + atan_tab(i_r);
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            a_r <= a_r - atan_tab(i_r);
          end
        end
        i_r <= i_r + 1'b1;
        if (zero_r || i_r == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign angle = a_r;

endmodule
